/* rtl/core/vertex_dedup_indexer_assert.svh */
// Assertion macros for the vertex deduplication indexer.
// The macros expect clk_i and rst_ni to be visible where they are used.
`ifndef VERTEX_DEDUP_INDEXER_ASSERT_SVH
`define VERTEX_DEDUP_INDEXER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is active.
`define VDI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define VDI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define VDI_ASSERT_IMP(lbl, ante, cons, msg)
`define VDI_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/core/vdi_pkg.sv */
package vdi_pkg;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned KEY_WORDS     = 4;
  localparam int unsigned WORD_W        = 64;
  localparam int unsigned STORE_DEPTH   = TABLE_ENTRIES * KEY_WORDS;
  localparam int unsigned ENTRY_W       = $clog2(TABLE_ENTRIES);
  localparam int unsigned COUNT_W       = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned WSEL_W        = $clog2(KEY_WORDS);
  localparam int unsigned ADDR_W        = ENTRY_W + WSEL_W;
  localparam int unsigned INDEX_W       = 10;

  typedef struct packed {
    logic        first_of_mesh;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
  } vdi_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] vertex_index;
    logic               is_new;
    logic               table_full;
  } vdi_out_t;

  // Control of the shared word comparator, one key word per cycle.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } vdi_cmp_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_WRITE  = 4'b0100,
    ST_FINISH = 4'b1000
  } vdi_state_e;

  // The 256-bit key is held as four 64-bit words, low half first.
  function automatic logic [WORD_W-1:0] key_word(input vdi_in_t v,
                                                 input logic [WSEL_W-1:0] w);
    logic [WORD_W-1:0] word;
    unique case (w)
      2'd0:    word = {v.pos_y, v.pos_x};
      2'd1:    word = {v.tex_u, v.pos_z};
      2'd2:    word = {v.norm_x, v.tex_v};
      default: word = {v.norm_z, v.norm_y};
    endcase
    return word;
  endfunction

  // Low bits of a table index, zero-extended when the table is narrow.
  function automatic logic [INDEX_W-1:0] to_index(input logic [ENTRY_W-1:0] e);
    logic [ENTRY_W+INDEX_W-1:0] wide;
    wide = {{INDEX_W{1'b0}}, e};
    return wide[INDEX_W-1:0];
  endfunction

endpackage

/* rtl/core/vertex_dedup_indexer.sv */
// Channel | Direction | Handshake             | Payload
// input   | in        | in_valid_i/in_ready_o | in_data_i  (vdi_in_t)
// output  | out       | out_valid_o/out_ready_i | out_data_o (vdi_out_t)
//
// One item at a time; one key word is read and compared per cycle through a
// single store read port and one 64-bit comparator, so a lookup reads the
// stored entries word by word, and an append writes the four key words.
// A hit ends the scan early. in_ready_o is high only while idle.
// Reset clears the entry count; the key store itself is never cleared.
// A stalled output holds the finished item while the next one is taken.
`include "vertex_dedup_indexer_assert.svh"

module vertex_dedup_indexer import vdi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  vdi_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output vdi_out_t out_data_o
);

  localparam logic [WSEL_W-1:0] WSEL_LAST = WSEL_W'(KEY_WORDS - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(TABLE_ENTRIES);

  vdi_state_e state_q, state_d;
  vdi_in_t    in_q, in_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [COUNT_W-1:0] count_eff;
  logic [COUNT_W-1:0] count_m1;
  logic [ENTRY_W-1:0] last_entry;
  logic               iss_active_q, iss_active_d;
  logic [ENTRY_W-1:0] iss_entry_q, iss_entry_d;
  logic [WSEL_W-1:0]  iss_wsel_q, iss_wsel_d;
  logic               rd_valid_q, rd_valid_d;
  logic [ENTRY_W-1:0] rd_entry_q, rd_entry_d;
  logic [WSEL_W-1:0]  rd_wsel_q, rd_wsel_d;
  vdi_out_t           res_q, res_d;
  vdi_out_t           out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  vdi_cmp_ctrl_t cmp_ctrl;
  logic          cmp_hit;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign count_m1   = COUNT_W'(count_q - 1'b1);
  assign last_entry = count_m1[ENTRY_W-1:0];
  assign count_eff  = in_data_i.first_of_mesh ? '0 : count_q;

  assign ram_raddr = {iss_entry_q, iss_wsel_q};
  assign ram_waddr = {count_q[ENTRY_W-1:0], iss_wsel_q};
  assign ram_wdata = key_word(in_q, iss_wsel_q);

  assign cmp_ctrl.valid = rd_valid_q;
  assign cmp_ctrl.first = (rd_wsel_q == '0);
  assign cmp_ctrl.last  = (rd_wsel_q == WSEL_LAST);

  vdi_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_key_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  vdi_cmp u_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cmp_ctrl),
    .a_i    (ram_rdata),
    .b_i    (key_word(in_q, rd_wsel_q)),
    .hit_o  (cmp_hit)
  );

  always_comb begin
    state_d      = state_q;
    in_d         = in_q;
    count_d      = count_q;
    iss_active_d = iss_active_q;
    iss_entry_d  = iss_entry_q;
    iss_wsel_d   = iss_wsel_q;
    rd_valid_d   = 1'b0;
    rd_entry_d   = rd_entry_q;
    rd_wsel_d    = rd_wsel_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_d        = in_data_i;
          count_d     = count_eff;
          iss_entry_d = '0;
          iss_wsel_d  = '0;
          if (count_eff == '0) begin
            state_d = ST_WRITE;
          end else begin
            iss_active_d = 1'b1;
            state_d      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Reads are issued in the cycle before the compare that consumes them.
        rd_valid_d = iss_active_q;
        rd_entry_d = iss_entry_q;
        rd_wsel_d  = iss_wsel_q;
        if (iss_active_q) begin
          ram_re     = 1'b1;
          iss_wsel_d = WSEL_W'(iss_wsel_q + 1'b1);
          if (iss_wsel_q == WSEL_LAST) begin
            if (iss_entry_q == last_entry) begin
              iss_active_d = 1'b0;
            end else begin
              iss_entry_d = ENTRY_W'(iss_entry_q + 1'b1);
            end
          end
        end
        priority if (cmp_hit) begin
          res_d.vertex_index = to_index(rd_entry_q);
          res_d.is_new       = 1'b0;
          res_d.table_full   = 1'b0;
          iss_active_d       = 1'b0;
          rd_valid_d         = 1'b0;
          state_d            = ST_FINISH;
        end else if (rd_valid_q && (rd_wsel_q == WSEL_LAST) &&
                     (rd_entry_q == last_entry)) begin
          iss_active_d = 1'b0;
          rd_valid_d   = 1'b0;
          if (count_q == COUNT_MAX) begin
            res_d.vertex_index = '0;
            res_d.is_new       = 1'b0;
            res_d.table_full   = 1'b1;
            state_d            = ST_FINISH;
          end else begin
            iss_wsel_d = '0;
            state_d    = ST_WRITE;
          end
        end else begin
          // No decision yet, so the scan goes on.
          state_d = ST_SCAN;
        end
      end
      ST_WRITE: begin
        ram_we     = 1'b1;
        iss_wsel_d = WSEL_W'(iss_wsel_q + 1'b1);
        if (iss_wsel_q == WSEL_LAST) begin
          count_d            = COUNT_W'(count_q + 1'b1);
          res_d.vertex_index = to_index(count_q[ENTRY_W-1:0]);
          res_d.is_new       = 1'b1;
          res_d.table_full   = 1'b0;
          state_d            = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      iss_active_q <= 1'b0;
      iss_entry_q  <= '0;
      iss_wsel_q   <= '0;
      rd_valid_q   <= 1'b0;
      rd_entry_q   <= '0;
      rd_wsel_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      iss_active_q <= iss_active_d;
      iss_entry_q  <= iss_entry_d;
      iss_wsel_q   <= iss_wsel_d;
      rd_valid_q   <= rd_valid_d;
      rd_entry_q   <= rd_entry_d;
      rd_wsel_q    <= rd_wsel_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  `VDI_ASSERT_IMP(a_count_range, 1'b1, count_q <= COUNT_MAX, "entry count above table size")
  `VDI_ASSERT_IMP(a_write_not_full, ram_we, count_q < COUNT_MAX, "write into a full table")
  `VDI_ASSERT_IMP(a_hit_in_scan, cmp_hit, state_q == ST_SCAN, "compare hit outside a scan")
  `VDI_ASSERT_IMP(a_out_flags, out_valid_q, !(out_q.is_new && out_q.table_full), "new and full")
  `VDI_ASSERT_NXT(a_append_count, (state_q == ST_WRITE) && (iss_wsel_q == WSEL_LAST),
    (state_q == ST_FINISH) && (count_q == COUNT_W'($past(count_q) + 1'b1)), "append lost")

endmodule

/* rtl/core/vdi_ram.sv */
module vdi_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/vdi_cmp.sv */
module vdi_cmp import vdi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vdi_cmp_ctrl_t     ctrl_i,
  input  logic [WORD_W-1:0] a_i,
  input  logic [WORD_W-1:0] b_i,
  output logic              hit_o
);

  logic acc_q, acc_d;
  logic acc_cur;
  logic acc_new;

  // The accumulator restarts on the first word of each entry and ANDs in
  // every later word, so a hit means all key words matched.
  assign acc_cur = ctrl_i.first ? 1'b1 : acc_q;
  assign acc_new = acc_cur & (a_i == b_i);
  assign acc_d   = ctrl_i.valid ? acc_new : acc_q;
  assign hit_o   = ctrl_i.valid & ctrl_i.last & acc_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule
